FILE: rtl/core/assert_macros.svh
// Assertion macros for the page allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define BPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising clock edge outside reset.
`define BPA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/bpa_pkg.sv
// Package with constants, types and helper functions of the page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

    // Pool geometry.
    localparam int MAX_PAGES   = 1024;
    localparam int WORD_BITS   = 32;
    localparam int PAGE_SHIFT  = 12;
    localparam int NUM_WORDS   = MAX_PAGES / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int PAGE_IDX_W  = WORD_IDX_W + BIT_IDX_W;

    // Field and register widths.
    localparam int ADDR_W      = 32;
    localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
    localparam int BASE_W      = 20;
    localparam int COUNT_W     = 11;
    localparam int CFG_DATA_W  = 20;
    localparam int OUT_DATA_W  = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] LIMIT_MAX = COUNT_W'(MAX_PAGES);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_BASE_PAGE  = 1'b0,
        CFG_PAGE_COUNT = 1'b1
    } t_cfg_idx;

    // Request kinds.
    typedef enum logic [0:0] {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_REJECTED  = 2'd2
    } t_status;

    // Active pool configuration seen by the sequencer.
    typedef struct packed {
        logic [BASE_W-1:0]  base_page;
        logic [COUNT_W-1:0] limit;
    } t_cfg;

    // Bitmap memory access from the sequencer.
    typedef struct packed {
        logic                  we;
        logic [WORD_IDX_W-1:0] wr_addr;
        logic [WORD_BITS-1:0]  wdata;
        logic [WORD_IDX_W-1:0] rd_addr;
    } t_mem_req;

    // Finished result offered to the output register.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_res;

    // Index of the lowest set bit of a bitmap word (0 when the word is zero).
    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_IDX_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = BIT_IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/bitmap_page_allocator.sv
// Top level of the first-fit bitmap page allocator.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: free_addr, tuser: kind
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: page_addr, status
// cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// An allocate scans the bitmap words (0 to 32, one per cycle through the read port), writes
// the taken bit and offers the result, or offers it with no write when no page is free.
// A free runs an address check, a bitmap read, a read-modify-write and the result, or stops
// after the address check when that check refuses it.
// Synchronous reset marks every page free through per-row valid bits at once.
// A result waits in the output register; a stalled output holds the sequencer
// only when a second result is ready before the first is taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ADDR_W-1:0]     s_axis_tdata,   // [31:0] free_addr
    input  logic [0:0]            s_axis_tuser,   // [0] kind
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [31:0] page_addr, [33:32] status
);

    logic [BASE_W-1:0]  r_base_page;
    logic [COUNT_W-1:0] r_page_count;
    t_cfg               cfg;
    t_mem_req           mem_req;
    logic [WORD_BITS-1:0] mem_rdata;
    t_res               res;
    logic               res_take;
    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_out_addr;
    t_status            r_out_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_page  <= '0;
            r_page_count <= LIMIT_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BASE_PAGE:  r_base_page  <= i_cfg_data[BASE_W-1:0];
                CFG_PAGE_COUNT: r_page_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Usable pages stop at the bitmap capacity.
    assign cfg.base_page = r_base_page;
    assign cfg.limit     = (r_page_count > LIMIT_MAX) ? LIMIT_MAX : r_page_count;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req_kind  (t_kind'(s_axis_tuser[0])),
        .i_req_addr  (s_axis_tdata),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    bpa_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Output register: loads a finished result when empty or being drained.
    assign res_take = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res.valid) begin
            r_out_addr   <= res.addr;
            r_out_status <= res.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - ADDR_W - 2){1'b0}}, r_out_status, r_out_addr};

    // A failed request never carries a page address.
    `BPA_ASSERT(a_fail_addr_zero, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tdata[33:32] != ST_OK)) |-> (m_axis_tdata[31:0] == '0), "failed request returned a nonzero address")
    // The sequencer is busy in the cycle after it takes a beat.
    `BPA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "request port ready right after an accept")
    // A new result appears only after the sequencer was busy.
    `BPA_ASSERT(a_result_after_work, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared without a busy sequencer")
    // Allocated addresses stay page aligned.
    `BPA_NEVER(a_addr_aligned, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[11:0] != '0), "page address not aligned")

endmodule

FILE: rtl/core/bpa_bitmap.sv
// Free-page bitmap memory with per-row valid bits that read as all free.
`timescale 1ns / 1ps

module bpa_bitmap
    import bpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mem_req             i_req,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [NUM_WORDS-1:0] r_row_valid;
    logic                 r_rd_valid;

    // Memory array: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.rd_addr];
    end

    // Row valid bits: a row never written since reset holds all free pages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_row_valid[i_req.wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_row_valid[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : {WORD_BITS{1'b1}};

endmodule

FILE: rtl/core/bpa_ctrl.sv
// Request sequencer: word scan with a single first-set search reused for every word, and page frees.
`timescale 1ns / 1ps

module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_kind                i_req_kind,
    input  logic [ADDR_W-1:0]    i_req_addr,
    output t_mem_req             o_mem,
    input  logic [WORD_BITS-1:0] i_mem_rdata,
    output t_res                 o_res,
    input  logic                 i_res_take
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_A_SCAN = 7'b0000010,
        S_A_WR   = 7'b0000100,
        S_F_CHK  = 7'b0001000,
        S_F_RD   = 7'b0010000,
        S_F_WR   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    logic [WORD_IDX_W-1:0]  r_word, n_word;
    logic [WORD_IDX_W-1:0]  r_chk, n_chk;
    logic [PAGE_IDX_W-1:0]  r_idx, n_idx;
    logic [WORD_BITS-1:0]   r_wdata, n_wdata;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [ADDR_W-1:0]      r_res_addr, n_res_addr;
    t_status                r_res_status, n_res_status;
    logic [COUNT_W-1:0]     r_count, n_count;

    // Search unit and free bit-select signals.
    logic [COUNT_W-1:0]     word_start;
    logic [COUNT_W-1:0]     next_start;
    logic [COUNT_W-1:0]     remain;
    logic [WORD_BITS-1:0]   limit_mask;
    logic [WORD_BITS-1:0]   masked;
    logic [BIT_IDX_W-1:0]   hit_bit;
    logic [WORD_BITS-1:0]   bit_sel;

    // Free address checks.
    logic [PAGE_NUM_W-1:0]  page_num;
    logic [PAGE_NUM_W-1:0]  page_off;
    logic                   free_bad;
    logic [PAGE_NUM_W-1:0]  alloc_page;

    // Mask off pages at or beyond the pool limit inside the word being checked.
    always_comb begin
        word_start = {{(COUNT_W - PAGE_IDX_W){1'b0}}, r_chk, {BIT_IDX_W{1'b0}}};
        next_start = COUNT_W'({1'b0, r_chk} + 1'b1) << BIT_IDX_W;
        remain     = i_cfg.limit - word_start;
        if (remain >= COUNT_W'(WORD_BITS)) begin
            limit_mask = {WORD_BITS{1'b1}};
        end else begin
            limit_mask = (WORD_BITS'(1) << remain[BIT_IDX_W-1:0]) - WORD_BITS'(1);
        end
        masked  = i_mem_rdata & limit_mask;
        hit_bit = lowest_set(masked);
        bit_sel = WORD_BITS'(1) << r_idx[BIT_IDX_W-1:0];
    end

    // Free address to pool index, and the allocated page number.
    always_comb begin
        page_num   = r_addr[ADDR_W-1:PAGE_SHIFT];
        page_off   = page_num - i_cfg.base_page;
        free_bad   = (page_num < i_cfg.base_page) || (r_count == '0) ||
                     (page_off >= PAGE_NUM_W'(i_cfg.limit));
        alloc_page = i_cfg.base_page + PAGE_NUM_W'(r_idx);
    end

    // Sequencer next state.
    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_chk        = r_chk;
        n_idx        = r_idx;
        n_wdata      = r_wdata;
        n_addr       = r_addr;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_count      = r_count;
        o_mem.we      = 1'b0;
        o_mem.wr_addr = r_idx[PAGE_IDX_W-1:BIT_IDX_W];
        o_mem.wdata   = r_wdata;
        o_mem.rd_addr = r_word;

        unique case (r_state)
            S_IDLE: begin
                // Word 0 is read here so the scan sees it on its first cycle.
                o_mem.rd_addr = '0;
                if (i_req_valid) begin
                    n_addr       = i_req_addr;
                    n_res_addr   = '0;
                    n_res_status = ST_OK;
                    n_word       = WORD_IDX_W'(1);
                    n_chk        = '0;
                    if (i_req_kind == KIND_FREE) begin
                        n_state = S_F_CHK;
                    end else if (i_cfg.limit == '0) begin
                        n_res_status = ST_EXHAUSTED;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_A_SCAN;
                    end
                end
            end
            S_A_SCAN: begin
                // One word checked per cycle while the next one is read.
                if (masked != '0) begin
                    n_idx   = {r_chk, hit_bit};
                    n_wdata = i_mem_rdata & ~(WORD_BITS'(1) << hit_bit);
                    n_state = S_A_WR;
                end else if (next_start >= i_cfg.limit) begin
                    n_res_status = ST_EXHAUSTED;
                    n_state      = S_DONE;
                end else begin
                    n_chk  = r_chk + 1'b1;
                    n_word = r_word + 1'b1;
                end
            end
            S_A_WR: begin
                o_mem.we   = 1'b1;
                n_res_addr = {alloc_page, {PAGE_SHIFT{1'b0}}};
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
                n_state = S_DONE;
            end
            S_F_CHK: begin
                if (free_bad) begin
                    n_res_status = ST_REJECTED;
                    n_state      = S_DONE;
                end else begin
                    n_idx   = page_off[PAGE_IDX_W-1:0];
                    n_word  = page_off[PAGE_IDX_W-1:BIT_IDX_W];
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                n_state = S_F_WR;
            end
            S_F_WR: begin
                // A page that is already free is a double free.
                if ((i_mem_rdata & bit_sel) != '0) begin
                    n_res_status = ST_REJECTED;
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.wdata = i_mem_rdata | bit_sel;
                    n_count     = r_count - 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_word  <= '0;
            r_chk   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_word  <= n_word;
            r_chk   <= n_chk;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_wdata      <= n_wdata;
        r_addr       <= n_addr;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.addr   = r_res_addr;
    assign o_res.status = r_res_status;

endmodule
